### src/assert_macros.svh
// Assertion macros for the RTL of the vector store engine.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### src/bvse_pkg.sv
// Types and codes of the vector store engine.
// No dependencies; used by bvse_ctrl, bounded_vector_store_engine, vector_store_checker and tb_top.
`default_nettype none

package bvse_pkg;

  typedef enum logic [2:0] {
    ACT_GET       = 3'd0,
    ACT_SET       = 3'd1,
    ACT_APPEND    = 3'd2,
    ACT_RM_FIRST  = 3'd3,
    ACT_RM_LAST   = 3'd4,
    ACT_RM_AT     = 3'd5,
    ACT_RM_VALUE  = 3'd6,
    ACT_CLEAR     = 3'd7
  } action_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_EMPTY = 2'd2,
    STAT_FULL  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SHIFT,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic    found;
    status_t status;
  } res_info_t;

endpackage

`default_nettype wire

### src/bvse_mem.sv
// Simple dual-port element store: one write and one registered read per cycle.
// No dependencies.
`default_nettype none

module bvse_mem #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### src/bvse_ctrl.sv
// Sequencer of the vector store engine: decodes actions, walks the store
// for shifts and searches, and keeps the head and tail positions. Uses bvse_pkg.
`default_nettype none

module bvse_ctrl #(
  parameter int CAPACITY      = 256,
  parameter int ELEMENT_WIDTH = 32,
  parameter int PW            = 9,
  parameter int AW            = 8
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [2:0]               action,
  input  wire logic [15:0]              position,
  input  wire logic [ELEMENT_WIDTH-1:0] wval,
  output logic                          mem_we,
  output logic      [AW-1:0]            mem_waddr,
  output logic      [ELEMENT_WIDTH-1:0] mem_wdata,
  output logic      [AW-1:0]            mem_raddr,
  input  wire logic [ELEMENT_WIDTH-1:0] mem_rdata,
  output logic                          res_valid,
  input  wire logic                     res_ready,
  output logic      [ELEMENT_WIDTH-1:0] res_value,
  output bvse_pkg::res_info_t           res_info,
  output logic      [PW-1:0]            res_count
);

  localparam int CW = (PW > 16) ? PW : 16;

  bvse_pkg::state_t  state, state_next;
  bvse_pkg::action_t act, act_next;
  bvse_pkg::status_t status, status_next;
  logic [PW-1:0] head, head_next, tail, tail_next, sh, sh_next, wa, wa_next;
  logic [ELEMENT_WIDTH-1:0] wval_r, wval_r_next, rd, rd_next;
  logic found, found_next, capture, capture_next;

  logic [PW-1:0] n, last, rslot, slot;
  logic [CW-1:0] pos_c, slot_c;
  logic          bad_pos;

  assign n      = tail - head;
  assign last   = tail - PW'(2);
  assign pos_c  = CW'(position);
  assign slot_c = CW'(head) + pos_c - CW'(2);
  assign slot   = slot_c[PW-1:0];
  assign bad_pos = (pos_c == '0) || (pos_c > CW'(n));

  assign in_ready  = (state == bvse_pkg::ST_IDLE);
  assign res_valid = (state == bvse_pkg::ST_DONE);
  assign res_value = rd;
  assign res_info  = '{found: found, status: status};
  assign res_count = n;
  assign mem_raddr = rslot[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bvse_pkg::ST_IDLE;
      head  <= PW'(1);
      tail  <= PW'(1);
    end else begin
      state <= state_next;
      head  <= head_next;
      tail  <= tail_next;
    end
  end

  always_ff @(posedge clk) begin
    act     <= act_next;
    status  <= status_next;
    sh      <= sh_next;
    wa      <= wa_next;
    wval_r  <= wval_r_next;
    rd      <= rd_next;
    found   <= found_next;
    capture <= capture_next;
  end

  always_comb begin
    state_next   = state;
    act_next     = act;
    status_next  = status;
    head_next    = head;
    tail_next    = tail;
    sh_next      = sh;
    wa_next      = wa;
    wval_r_next  = wval_r;
    rd_next      = rd;
    found_next   = found;
    capture_next = capture;
    rslot        = sh + PW'(1);
    mem_we       = 1'b0;
    mem_waddr    = wa[AW-1:0];
    mem_wdata    = wval_r;
    case (state)
      bvse_pkg::ST_IDLE: begin
        if (in_valid) begin
          act_next     = bvse_pkg::action_t'(action);
          wval_r_next  = wval;
          rd_next      = '0;
          found_next   = 1'b0;
          status_next  = bvse_pkg::STAT_OK;
          capture_next = 1'b1;
          state_next   = bvse_pkg::ST_DONE;
          case (bvse_pkg::action_t'(action))
            bvse_pkg::ACT_GET, bvse_pkg::ACT_SET: begin
              if (bad_pos) begin
                status_next = bvse_pkg::STAT_RANGE;
              end else begin
                rslot      = slot;
                wa_next    = slot;
                state_next = bvse_pkg::ST_READ;
              end
            end
            bvse_pkg::ACT_APPEND: begin
              if (tail > PW'(CAPACITY)) begin
                status_next = bvse_pkg::STAT_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = AW'(tail - PW'(1));
                mem_wdata = wval;
                tail_next = tail + PW'(1);
              end
            end
            bvse_pkg::ACT_RM_FIRST: begin
              if (n == '0) begin
                status_next = bvse_pkg::STAT_EMPTY;
              end else begin
                rslot      = head - PW'(1);
                state_next = bvse_pkg::ST_READ;
              end
            end
            bvse_pkg::ACT_RM_LAST: begin
              if (n == '0) begin
                status_next = bvse_pkg::STAT_EMPTY;
              end else begin
                rslot      = last;
                sh_next    = last;
                state_next = bvse_pkg::ST_SHIFT;
              end
            end
            bvse_pkg::ACT_RM_AT: begin
              if (bad_pos) begin
                status_next = bvse_pkg::STAT_RANGE;
              end else begin
                rslot      = slot;
                sh_next    = slot;
                state_next = bvse_pkg::ST_SHIFT;
              end
            end
            bvse_pkg::ACT_RM_VALUE: begin
              if (n != '0) begin
                rslot      = head - PW'(1);
                sh_next    = head - PW'(1);
                state_next = bvse_pkg::ST_SCAN;
              end
            end
            default: begin
              head_next = PW'(1);
              tail_next = PW'(1);
            end
          endcase
        end
      end
      bvse_pkg::ST_READ: begin
        rd_next    = mem_rdata;
        state_next = bvse_pkg::ST_DONE;
        if (act == bvse_pkg::ACT_SET) begin
          mem_we = 1'b1;
        end
        if (act == bvse_pkg::ACT_RM_FIRST) begin
          head_next = head + PW'(1);
        end
      end
      bvse_pkg::ST_SHIFT: begin
        // Data of slot sh arrives now; it moves down one slot while sh+1 is read.
        sh_next = sh + PW'(1);
        if (capture) begin
          rd_next      = mem_rdata;
          capture_next = 1'b0;
        end else if (sh <= last) begin
          mem_we    = 1'b1;
          mem_waddr = AW'(sh - PW'(1));
          mem_wdata = mem_rdata;
        end else begin
          tail_next  = tail - PW'(1);
          state_next = bvse_pkg::ST_DONE;
        end
      end
      bvse_pkg::ST_SCAN: begin
        sh_next = sh + PW'(1);
        if (mem_rdata == wval_r) begin
          rd_next      = mem_rdata;
          found_next   = 1'b1;
          capture_next = 1'b0;
          state_next   = bvse_pkg::ST_SHIFT;
        end else if (sh == last) begin
          state_next = bvse_pkg::ST_DONE;
        end
      end
      bvse_pkg::ST_DONE: begin
        if (res_ready) begin
          state_next = bvse_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = bvse_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### src/bounded_vector_store_engine.sv
// Top level of the bounded vector store engine: sequencer, element store
// and result register. Depends on bvse_pkg, bvse_ctrl, bvse_mem, assert_macros.svh.
//
// Usage. Each input transaction (action, position, element_value) carries one
// action on a vector held in a store of CAPACITY entries, and produces exactly
// one output transaction (read_value, found, status, element_count).
// Both channels use valid/ready; a transaction completes when both are high.
// Clear, append, error cases and remove_value on an empty vector go straight to
// the result; get, set and remove_first read one slot first. Remove_at and
// remove_last read the removed element, then move each element behind it down
// one slot; remove_value scans from the front until a match or the last element,
// and on a match shifts the rest down likewise. The walk is set by the single
// read and single write port of the store, walked one slot a cycle.
// The next input can be taken in the cycle after the result register is loaded.
// One action is in flight at a time; the next input transaction is taken
// as soon as the result reaches the output register, even if the receiver
// has not yet taken it. A stalled receiver holds the result register, and
// a second finished result then waits inside the sequencer.
// Reset empties the vector (head and tail return to slot one); the store
// itself is not cleared, as no slot is read before it is written.
`default_nettype none
`include "assert_macros.svh"

module bounded_vector_store_engine #(
  parameter int CAPACITY      = 256,
  parameter int ELEMENT_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  action,
  input  wire logic [15:0] position,
  input  wire logic [31:0] element_value,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      read_value,
  output logic             found,
  output logic [1:0]       status,
  output logic [8:0]       element_count
);

  // Slot positions run from 1 to CAPACITY+1, so they need one more code.
  localparam int PW = $clog2(CAPACITY + 2);
  localparam int AW = $clog2(CAPACITY);

  logic [63:0]              in_wide, out_wide;
  logic [ELEMENT_WIDTH-1:0] wval;
  logic                     mem_we;
  logic [AW-1:0]            mem_waddr, mem_raddr;
  logic [ELEMENT_WIDTH-1:0] mem_wdata, mem_rdata;
  logic                     res_valid, res_ready;
  logic [ELEMENT_WIDTH-1:0] res_value;
  bvse_pkg::res_info_t      res_info;
  logic [PW-1:0]            res_count;

  // Only the low ELEMENT_WIDTH bits of a value are kept.
  assign in_wide  = 64'(element_value);
  assign wval     = in_wide[ELEMENT_WIDTH-1:0];
  assign out_wide = 64'(res_value);

  bvse_ctrl #(
    .CAPACITY      (CAPACITY),
    .ELEMENT_WIDTH (ELEMENT_WIDTH),
    .PW            (PW),
    .AW            (AW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .action    (action),
    .position  (position),
    .wval      (wval),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_value (res_value),
    .res_info  (res_info),
    .res_count (res_count)
  );

  bvse_mem #(
    .DEPTH (CAPACITY),
    .WIDTH (ELEMENT_WIDTH)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // The result register takes a new result whenever it is empty or being emptied.
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      read_value    <= out_wide[31:0];
      found         <= res_info.found;
      status        <= res_info.status;
      element_count <= 9'(res_count);
    end
  end

  `ASSERT_NEXT(a_one_in_flight, clk, rst, in_valid && in_ready, !in_ready, "second accepted")
  `ASSERT_IMPL(a_found_ok, clk, rst, out_valid && found, status == bvse_pkg::STAT_OK, "found error")
  `ASSERT_IMPL(a_err_zero, clk, rst, out_valid && (status != bvse_pkg::STAT_OK), read_value == 32'd0, "error data")
  `ASSERT_NEXT(a_load_valid, clk, rst, res_valid && res_ready, out_valid, "result lost on load")

endmodule

`default_nettype wire

### sim/vector_store_checker.sv
// Checker for the bounded vector store engine: watches both channels, keeps its
// own copy of the vector, predicts each result and compares. Depends on bvse_pkg.
module vector_store_checker #(
  parameter int CAPACITY = 256
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic [2:0]  action,
  input  wire logic [15:0] position,
  input  wire logic [31:0] element_value,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic [31:0] read_value,
  input  wire logic        found,
  input  wire logic [1:0]  status,
  input  wire logic [8:0]  element_count,
  output int               fail_count,
  output int               pending_count
);

  typedef struct packed {
    logic [31:0]       rd;
    logic              fnd;
    bvse_pkg::status_t st;
    logic [8:0]        cnt;
  } vec_result_t;

  logic [31:0]  shadow_store [CAPACITY];
  int unsigned  head_slot;
  int unsigned  tail_slot;
  vec_result_t  expected_results [$];

  assign pending_count = expected_results.size();

  // Takes the element at 1-based index idx out, shifting the rest down.
  function automatic logic [31:0] take_out(int unsigned idx);
    int unsigned base;
    int unsigned n;
    logic [31:0] item;
    base = head_slot - 1;
    n = tail_slot - head_slot;
    item = shadow_store[base + idx - 1];
    for (int unsigned i = idx; i < n; i++) begin
      shadow_store[base + i - 1] = shadow_store[base + i];
    end
    tail_slot--;
    return item;
  endfunction

  function automatic vec_result_t apply_action(bvse_pkg::action_t act, int unsigned pos,
                                               logic [31:0] val);
    vec_result_t r;
    int unsigned n;
    int unsigned base;
    r = '{rd: '0, fnd: 1'b0, st: bvse_pkg::STAT_OK, cnt: '0};
    n = tail_slot - head_slot;
    base = head_slot - 1;
    case (act)
      bvse_pkg::ACT_GET, bvse_pkg::ACT_SET, bvse_pkg::ACT_RM_AT: begin
        if (pos < 1 || pos > n) begin
          r.st = bvse_pkg::STAT_RANGE;
        end else if (act == bvse_pkg::ACT_RM_AT) begin
          r.rd = take_out(pos);
        end else begin
          r.rd = shadow_store[base + pos - 1];
          if (act == bvse_pkg::ACT_SET) shadow_store[base + pos - 1] = val;
        end
      end
      bvse_pkg::ACT_APPEND: begin
        if (tail_slot - 1 >= CAPACITY) begin
          r.st = bvse_pkg::STAT_FULL;
        end else begin
          shadow_store[tail_slot - 1] = val;
          tail_slot++;
        end
      end
      bvse_pkg::ACT_RM_FIRST: begin
        if (n == 0) begin
          r.st = bvse_pkg::STAT_EMPTY;
        end else begin
          r.rd = shadow_store[base];
          head_slot++;
        end
      end
      bvse_pkg::ACT_RM_LAST: begin
        if (n == 0) r.st = bvse_pkg::STAT_EMPTY;
        else r.rd = take_out(n);
      end
      bvse_pkg::ACT_RM_VALUE: begin
        for (int unsigned i = 0; i < n; i++) begin
          if (shadow_store[base + i] == val) begin
            r.rd = take_out(i + 1);
            r.fnd = 1'b1;
            break;
          end
        end
      end
      default: begin
        head_slot = 1;
        tail_slot = 1;
      end
    endcase
    r.cnt = 9'(tail_slot - head_slot);
    return r;
  endfunction

  always @(posedge clk) begin
    vec_result_t exp_r;
    if (rst) begin
      head_slot = 1;
      tail_slot = 1;
      fail_count <= 0;
      expected_results.delete();
    end else begin
      if (in_valid && in_ready) begin
        expected_results.push_back(apply_action(bvse_pkg::action_t'(action), position,
                                                element_value));
      end
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result rd=%h found=%b status=%0d count=%0d",
                   $time, read_value, found, status, element_count);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = expected_results.pop_front();
          if (exp_r.rd !== read_value || exp_r.fnd !== found ||
              exp_r.st !== status || exp_r.cnt !== element_count) begin
            $display("%0t: mismatch expected rd=%h found=%b status=%0d count=%0d",
                     $time, exp_r.rd, exp_r.fnd, exp_r.st, exp_r.cnt);
            $display("%0t:          actual   rd=%h found=%b status=%0d count=%0d",
                     $time, read_value, found, status, element_count);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

### sim/tb_top.sv
// Testbench top for the bounded vector store engine: drives actions, stalls
// the result side and gives the verdict. Depends on bvse_pkg and vector_store_checker.
module tb_top;

  localparam int CAPACITY  = 256;
  localparam int IDLE_MAX  = 20000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  action = '0;
  logic [15:0] position = '0;
  logic [31:0] element_value = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] read_value;
  logic        found;
  logic [1:0]  status;
  logic [8:0]  element_count;
  int          fail_count;
  int          pending_count;
  int          idle_cycles = 0;

  // The testbench keeps its own count of live elements, so that random
  // positions can be aimed mostly at valid indices.
  int          live_elems = 0;
  logic [31:0] recent_values [$];

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  bounded_vector_store_engine #(.CAPACITY(CAPACITY), .ELEMENT_WIDTH(32)) u_dut (
    .clk, .rst, .in_valid, .in_ready, .action, .position, .element_value,
    .out_valid, .out_ready, .read_value, .found, .status, .element_count
  );

  vector_store_checker #(.CAPACITY(CAPACITY)) u_checker (
    .clk, .rst, .in_valid, .in_ready, .action, .position, .element_value,
    .out_valid, .out_ready, .read_value, .found, .status, .element_count,
    .fail_count, .pending_count
  );

  function automatic int gap_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // The result side stalls in bursts; some stretches run with ready held high.
  initial begin
    int stall;
    @(posedge clk);
    while (1) begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : gap_length();
      repeat (stall) @(posedge clk);
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      out_ready <= 1'b0;
    end
  end

  // Watchdog: the run is stopped if nothing is accepted for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (!rst) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_MAX) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // Rough local count after an action: exact except for the store-full and
  // remove-by-value cases, where it is refreshed from the block's results.
  function automatic int element_count_guess(bvse_pkg::action_t act, int unsigned pos);
    case (act)
      bvse_pkg::ACT_APPEND:
        return (live_elems < CAPACITY) ? live_elems + 1 : live_elems;
      bvse_pkg::ACT_RM_FIRST, bvse_pkg::ACT_RM_LAST:
        return (live_elems > 0) ? live_elems - 1 : 0;
      bvse_pkg::ACT_RM_AT:
        return (pos >= 1 && pos <= live_elems) ? live_elems - 1 : live_elems;
      bvse_pkg::ACT_CLEAR:
        return 0;
      default:
        return live_elems;
    endcase
  endfunction

  // Sends one transaction, holding it until accepted. The local count of live
  // elements tracks the outcome so later positions stay mostly in range.
  task automatic send(bvse_pkg::action_t act, int unsigned pos, logic [31:0] val,
                      bit with_gap = 1'b1);
    int g;
    g = with_gap ? gap_length() : 0;
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    position <= 16'(pos);
    element_value <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    case (act)
      bvse_pkg::ACT_APPEND: begin
        recent_values.push_back(val);
        if (recent_values.size() > 16) void'(recent_values.pop_front());
      end
      bvse_pkg::ACT_CLEAR: live_elems = 0;
      default: ;
    endcase
    live_elems = element_count_guess(act, pos);
  endtask

  always @(posedge clk) begin
    if (out_valid && out_ready) live_elems = element_count;
  end

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_value();
    if (recent_values.size() != 0 && $urandom_range(0, 2) != 0)
      return recent_values[$urandom_range(0, recent_values.size() - 1)];
    if ($urandom_range(0, 3) == 0) return 32'($urandom_range(0, 7));
    return $urandom;
  endfunction

  function automatic int unsigned pick_position();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 0;
    if (r == 1) return $urandom_range(0, 65535);
    if (r == 2) return live_elems + 1;
    if (live_elems == 0) return $urandom_range(0, 3);
    return $urandom_range(1, live_elems);
  endfunction

  initial begin
    bvse_pkg::action_t act;
    int      r;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: errors on the empty vector, field extremes, every action.
    send(bvse_pkg::ACT_RM_FIRST, 0, 32'h0);
    send(bvse_pkg::ACT_RM_LAST, 0, 32'h0);
    send(bvse_pkg::ACT_RM_AT, 1, 32'h0);
    send(bvse_pkg::ACT_GET, 0, 32'h0);
    send(bvse_pkg::ACT_APPEND, 0, 32'hFFFF_FFFF);
    send(bvse_pkg::ACT_APPEND, 16'hFFFF, 32'h0);
    send(bvse_pkg::ACT_APPEND, 0, 32'h1234_5678);
    send(bvse_pkg::ACT_APPEND, 0, 32'h0);
    send(bvse_pkg::ACT_GET, 16'hFFFF, 32'h0);
    send(bvse_pkg::ACT_GET, 1, 32'h0);
    send(bvse_pkg::ACT_SET, 2, 32'hA5A5_5A5A);
    send(bvse_pkg::ACT_SET, 5, 32'h1);
    send(bvse_pkg::ACT_RM_VALUE, 0, 32'h0);        // match on the last element
    send(bvse_pkg::ACT_RM_VALUE, 0, 32'hDEAD_BEEF); // no match
    send(bvse_pkg::ACT_RM_AT, 2, 32'h0);
    send(bvse_pkg::ACT_RM_FIRST, 0, 32'h0);
    send(bvse_pkg::ACT_RM_LAST, 0, 32'h0);
    send(bvse_pkg::ACT_CLEAR, 0, 32'h0);

    // Fill the store to the brim, hit the full case, remove from the full store, then clear.
    for (int i = 0; i < CAPACITY + 2; i++) begin
      send(bvse_pkg::ACT_APPEND, i, $urandom, i % 8 == 0);
    end
    send(bvse_pkg::ACT_RM_FIRST, 0, 32'h0);
    send(bvse_pkg::ACT_APPEND, 0, 32'h5);           // freed front slot is not reused
    send(bvse_pkg::ACT_RM_AT, 1, 32'h0);            // longest shift
    send(bvse_pkg::ACT_RM_VALUE, 0, 32'hFFFF_FFFF);
    wait_drained();                        // sender holds off until all results arrive
    send(bvse_pkg::ACT_CLEAR, 0, 32'h0);

    // Random part: mostly in-range operations on a vector kept at modest size.
    for (int n = 0; n < 670; n++) begin
      r = $urandom_range(0, 99);
      if (r < 30 && live_elems < 40) act = bvse_pkg::ACT_APPEND;
      else if (r < 45) act = bvse_pkg::ACT_GET;
      else if (r < 57) act = bvse_pkg::ACT_SET;
      else if (r < 65) act = bvse_pkg::ACT_RM_FIRST;
      else if (r < 73) act = bvse_pkg::ACT_RM_LAST;
      else if (r < 83) act = bvse_pkg::ACT_RM_AT;
      else if (r < 95) act = bvse_pkg::ACT_RM_VALUE;
      else if (r < 97) act = bvse_pkg::ACT_CLEAR;
      else act = bvse_pkg::action_t'($urandom_range(0, 7));
      if (n % 300 == 150) wait_drained();
      // In-flight results can lag the local count; drain before range-aimed ops
      // only occasionally, since the block itself takes one action at a time.
      send(act, pick_position(), pick_value(), n % 100 > 20);
    end

    wait_drained();
    repeat (2 * CAPACITY + 20) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
